/* hdl/chte_pkg.sv */
// Shared codes and constants for the coalesced hash table engine.
package chte_pkg;

  // operation codes
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  // fixed port widths
  localparam int KEY_W   = 64;
  localparam int HASH_W  = 32;
  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 9;

endpackage

/* hdl/coalesced_hash_table_engine.sv */
// Coalesced chained-scatter hash table engine with a small sequencer.
//
// Command channel: an operation (lookup, insert/update, remove) is taken at
// a clock edge where start is high and busy is low. busy stays high while
// the sequencer works on it. Exactly one result is shown on the out_ ports
// for one cycle, marked by out_strobe; the receiver cannot stall it.
// All bucket and entry accesses go through one read and one write port of
// each of two memories, one access per sequencer step with a wait state
// for the registered read data. A lookup walks the chain from the home
// bucket, reading each bucket and then its entry; a miss at an empty home
// bucket ends after the bucket read. The result is shown while the
// sequencer is already idle, so the next operation can be taken in that
// cycle. An insert also scans for a free bucket and walks a chain during
// relinking; a remove walks a chain to relocate the last dense entry.
// After reset the bucket memory is cleared one bucket per cycle with busy
// high; the table then starts empty.
// Result fields: found, read_value, status and the entry count afterward.
module coalesced_hash_table_engine #(
  parameter int CAPACITY   = 256,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_mode,
  input  logic [chte_pkg::KEY_W-1:0]      in_key,
  input  logic [chte_pkg::HASH_W-1:0]     in_hash,
  input  logic [chte_pkg::VALUE_W-1:0]    in_value,
  output logic                            out_strobe,
  output logic                            out_found,
  output logic [chte_pkg::VALUE_W-1:0]    out_read_value,
  output logic [1:0]                      out_status,
  output logic [chte_pkg::TOTAL_W-1:0]    out_entry_total
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = IW + 1;
  localparam int BW = 2 * CW;
  localparam int EW = KEY_BITS + IW + VALUE_BITS;

  // sequencer states
  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_F_RD   = 5'd2;
  localparam logic [4:0] S_F_B    = 5'd3;
  localparam logic [4:0] S_F_ERD  = 5'd4;
  localparam logic [4:0] S_F_E    = 5'd5;
  localparam logic [4:0] S_MISS   = 5'd6;
  localparam logic [4:0] S_HIT    = 5'd7;
  localparam logic [4:0] S_P_RD   = 5'd8;
  localparam logic [4:0] S_P_B    = 5'd9;
  localparam logic [4:0] S_FS     = 5'd10;
  localparam logic [4:0] S_FS_RD  = 5'd11;
  localparam logic [4:0] S_FS_B   = 5'd12;
  localparam logic [4:0] S_FS_END = 5'd13;
  localparam logic [4:0] S_C_RD   = 5'd14;
  localparam logic [4:0] S_C_E    = 5'd15;
  localparam logic [4:0] S_PP_RD  = 5'd16;
  localparam logic [4:0] S_PP_B   = 5'd17;
  localparam logic [4:0] S_MV     = 5'd18;
  localparam logic [4:0] S_TL_RD  = 5'd19;
  localparam logic [4:0] S_TL_B   = 5'd20;
  localparam logic [4:0] S_FIN    = 5'd21;
  localparam logic [4:0] S_R_LRD  = 5'd22;
  localparam logic [4:0] S_R_LE   = 5'd23;
  localparam logic [4:0] S_R_IRD  = 5'd24;
  localparam logic [4:0] S_R_IB   = 5'd25;
  localparam logic [4:0] S_R_EW   = 5'd26;
  localparam logic [4:0] S_R_LINK = 5'd27;
  localparam logic [4:0] S_R_PRD  = 5'd28;
  localparam logic [4:0] S_R_PB   = 5'd29;
  localparam logic [4:0] S_R_NRD  = 5'd30;
  localparam logic [4:0] S_R_NB   = 5'd31;

  // memories: bucket {slot, link} and dense entry {key, home, value}
  logic [BW-1:0] bmem [CAPACITY];
  logic [EW-1:0] emem [CAPACITY];
  logic [BW-1:0] b_rd_r;
  logic [EW-1:0] e_rd_r;

  logic          b_we, e_we;
  logic [IW-1:0] b_wa, e_wa;
  logic [BW-1:0] b_wd;
  logic [EW-1:0] e_wd;

  // control registers
  logic [5:0]    st_r, st_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] eidx_r, eidx_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [CW-1:0] fh_r, fh_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic          prev_v_r, prev_v_nxt;
  logic          ostb_r, ostb_nxt;

  // payload registers
  logic [1:0]            mode_r, mode_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [IW-1:0]         home_r, home_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [IW-1:0]         prev_r, prev_nxt;
  logic [IW-1:0]         bkt_r, bkt_nxt;
  logic [CW-1:0]         slot_r, slot_nxt;
  logic [CW-1:0]         link_r, link_nxt;
  logic [CW-1:0]         e_r, e_nxt;
  logic [CW-1:0]         hs_r, hs_nxt;
  logic [CW-1:0]         hl_r, hl_nxt;
  logic [IW-1:0]         fb_r, fb_nxt;
  logic [CW-1:0]         clr_r, clr_nxt;
  logic [EW-1:0]         lent_r, lent_nxt;
  logic                  ofound_r, ofound_nxt;
  logic [VALUE_BITS-1:0] orv_r, orv_nxt;
  logic [1:0]            ostat_r, ostat_nxt;

  // read data fields
  logic [CW-1:0]         rd_slot, rd_link;
  logic [KEY_BITS-1:0]   rd_key;
  logic [IW-1:0]         rd_home;
  logic [VALUE_BITS-1:0] rd_val;
  logic [63:0]           in_val64, out_val64;
  logic [31:0]           live32;

  assign rd_slot = b_rd_r[BW-1:CW];
  assign rd_link = b_rd_r[CW-1:0];
  assign rd_key  = e_rd_r[EW-1 -: KEY_BITS];
  assign rd_home = e_rd_r[VALUE_BITS +: IW];
  assign rd_val  = e_rd_r[VALUE_BITS-1:0];

  assign in_val64  = {32'd0, in_value};
  assign out_val64 = 64'(orv_r);
  assign live32    = 32'(live_r);

  assign busy            = (st_r != {1'b0, S_IDLE});
  assign out_strobe      = ostb_r;
  assign out_found       = ofound_r;
  assign out_read_value  = out_val64[chte_pkg::VALUE_W-1:0];
  assign out_status      = ostat_r;
  assign out_entry_total = live32[chte_pkg::TOTAL_W-1:0];

  // memory ports
  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[b_wa] <= b_wd;
    end
    if (e_we) begin
      emem[e_wa] <= e_wd;
    end
    b_rd_r <= bmem[idx_r];
    e_rd_r <= emem[eidx_r];
  end

  // sequencer
  always_comb begin
    logic [CW-1:0] lm1;
    logic [CW-1:0] fhm1;
    logic [CW-1:0] fh_use;
    logic [CW-1:0] tmp;
    lm1    = rd_link - CW'(1);
    fhm1   = fh_r - CW'(1);
    fh_use = (fh_r == '0) ? CW'(1) : fh_r;
    tmp    = '0;

    st_nxt     = st_r;
    idx_nxt    = idx_r;
    eidx_nxt   = eidx_r;
    live_nxt   = live_r;
    fh_nxt     = fh_r;
    step_nxt   = step_r;
    prev_v_nxt = prev_v_r;
    ostb_nxt   = 1'b0;
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    home_nxt   = home_r;
    val_nxt    = val_r;
    prev_nxt   = prev_r;
    bkt_nxt    = bkt_r;
    slot_nxt   = slot_r;
    link_nxt   = link_r;
    e_nxt      = e_r;
    hs_nxt     = hs_r;
    hl_nxt     = hl_r;
    fb_nxt     = fb_r;
    clr_nxt    = clr_r;
    lent_nxt   = lent_r;
    ofound_nxt = ofound_r;
    orv_nxt    = orv_r;
    ostat_nxt  = ostat_r;
    b_we = 1'b0;
    b_wa = idx_r;
    b_wd = '0;
    e_we = 1'b0;
    e_wa = eidx_r;
    e_wd = '0;

    unique case (st_r[4:0])
      // clearing pass over the bucket memory after reset, or final clear after a remove
      S_CLR: begin
        b_we = 1'b1;
        if (st_r[5]) begin
          // final clear of a removed bucket
          tmp  = clr_r - CW'(1);
          b_wa = tmp[IW-1:0];
          if (clr_r > fh_r) begin
            fh_nxt = clr_r;
          end
          ofound_nxt = 1'b1;
          orv_nxt    = '0;
          ostat_nxt  = chte_pkg::STAT_OK;
          ostb_nxt   = 1'b1;
          st_nxt     = {1'b0, S_IDLE};
        end else begin
          idx_nxt = idx_r + IW'(1);
          if (idx_r == IW'(CAPACITY - 1)) begin
            st_nxt = {1'b0, S_IDLE};
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          mode_nxt   = in_mode;
          key_nxt    = in_key[KEY_BITS-1:0];
          home_nxt   = in_hash[IW-1:0];
          val_nxt    = in_val64[VALUE_BITS-1:0];
          idx_nxt    = in_hash[IW-1:0];
          prev_v_nxt = 1'b0;
          step_nxt   = '0;
          st_nxt     = {1'b0, S_F_RD};
        end
      end
      // chain search
      S_F_RD: st_nxt = {1'b0, S_F_B};
      S_F_B: begin
        slot_nxt = rd_slot;
        link_nxt = rd_link;
        tmp      = rd_slot - CW'(1);
        eidx_nxt = tmp[IW-1:0];
        st_nxt   = (rd_slot == '0) ? {1'b0, S_MISS} : {1'b0, S_F_ERD};
      end
      S_F_ERD: st_nxt = {1'b0, S_F_E};
      S_F_E: begin
        priority if (rd_key == key_r) begin
          bkt_nxt = idx_r;
          st_nxt  = {1'b0, S_HIT};
        end else if (link_r == '0 || step_r + CW'(1) == CW'(CAPACITY)) begin
          st_nxt = {1'b0, S_MISS};
        end else begin
          tmp        = link_r - CW'(1);
          prev_nxt   = idx_r;
          prev_v_nxt = 1'b1;
          idx_nxt    = tmp[IW-1:0];
          step_nxt   = step_r + CW'(1);
          st_nxt     = {1'b0, S_F_RD};
        end
      end
      S_MISS: begin
        ofound_nxt = 1'b0;
        orv_nxt    = '0;
        if (mode_r == chte_pkg::MODE_INSERT) begin
          if (live_r >= CW'(CAPACITY)) begin
            ostat_nxt = chte_pkg::STAT_FULL;
            ostb_nxt  = 1'b1;
            st_nxt    = {1'b0, S_IDLE};
          end else begin
            live_nxt = live_r + CW'(1);
            e_nxt    = live_r + CW'(1);
            e_we     = 1'b1;
            e_wa     = live_r[IW-1:0];
            e_wd     = {key_r, home_r, val_r};
            idx_nxt  = home_r;
            st_nxt   = {1'b0, S_P_RD};
          end
        end else begin
          ostat_nxt = chte_pkg::STAT_NOT_FOUND;
          ostb_nxt  = 1'b1;
          st_nxt    = {1'b0, S_IDLE};
        end
      end
      S_HIT: begin
        ofound_nxt = 1'b1;
        ostat_nxt  = chte_pkg::STAT_OK;
        if (mode_r == chte_pkg::MODE_INSERT) begin
          e_we     = 1'b1;
          e_wd     = {key_r, rd_home, val_r};
          orv_nxt  = val_r;
          ostb_nxt = 1'b1;
          st_nxt   = {1'b0, S_IDLE};
        end else if (mode_r == chte_pkg::MODE_REMOVE) begin
          if (slot_r != live_r) begin
            tmp      = live_r - CW'(1);
            eidx_nxt = tmp[IW-1:0];
            st_nxt   = {1'b0, S_R_LRD};
          end else begin
            st_nxt = {1'b0, S_R_LINK};
          end
        end else begin
          orv_nxt  = rd_val;
          ostb_nxt = 1'b1;
          st_nxt   = {1'b0, S_IDLE};
        end
      end
      // placement of a new entry
      S_P_RD: st_nxt = {1'b0, S_P_B};
      S_P_B: begin
        if (rd_slot == '0) begin
          b_we      = 1'b1;
          b_wd      = {e_r, rd_link};
          orv_nxt   = val_r;
          ostat_nxt = chte_pkg::STAT_OK;
          ostb_nxt  = 1'b1;
          st_nxt    = {1'b0, S_IDLE};
        end else begin
          hs_nxt = rd_slot;
          hl_nxt = rd_link;
          st_nxt = {1'b0, S_FS};
        end
      end
      S_FS: begin
        if (fh_r > CW'(1)) begin
          idx_nxt = fhm1[IW-1:0];
          st_nxt  = {1'b0, S_FS_RD};
        end else begin
          st_nxt = {1'b0, S_FS_END};
        end
      end
      S_FS_RD: st_nxt = {1'b0, S_FS_B};
      S_FS_B: begin
        if (rd_slot != '0) begin
          fh_nxt = fhm1;
          st_nxt = {1'b0, S_FS};
        end else begin
          st_nxt = {1'b0, S_FS_END};
        end
      end
      S_FS_END: begin
        fh_nxt   = fh_use;
        tmp      = fh_use - CW'(1);
        fb_nxt   = tmp[IW-1:0];
        tmp      = hs_r - CW'(1);
        eidx_nxt = tmp[IW-1:0];
        st_nxt   = {1'b0, S_C_RD};
      end
      S_C_RD: st_nxt = {1'b0, S_C_E};
      S_C_E: begin
        step_nxt = '0;
        if (rd_home != home_r) begin
          idx_nxt = rd_home;
          st_nxt  = {1'b0, S_PP_RD};
        end else begin
          idx_nxt = home_r;
          st_nxt  = {1'b0, S_TL_RD};
        end
      end
      // find predecessor of the home bucket in the foreign chain
      S_PP_RD: st_nxt = {1'b0, S_PP_B};
      S_PP_B: begin
        if (rd_link == CW'(home_r) + CW'(1) || step_r == CW'(CAPACITY)) begin
          b_we   = 1'b1;
          b_wd   = {rd_slot, CW'(fb_r) + CW'(1)};
          st_nxt = {1'b0, S_MV};
        end else begin
          idx_nxt  = lm1[IW-1:0];
          step_nxt = step_r + CW'(1);
          st_nxt   = {1'b0, S_PP_RD};
        end
      end
      S_MV: begin
        b_we    = 1'b1;
        b_wa    = fb_r;
        b_wd    = {hs_r, hl_r};
        idx_nxt = home_r;
        st_nxt  = {1'b0, S_FIN};
      end
      // walk to the tail of the own chain
      S_TL_RD: st_nxt = {1'b0, S_TL_B};
      S_TL_B: begin
        if (rd_link == '0 || step_r == CW'(CAPACITY)) begin
          b_we    = 1'b1;
          b_wd    = {rd_slot, CW'(fb_r) + CW'(1)};
          idx_nxt = fb_r;
          st_nxt  = {1'b0, S_FIN};
        end else begin
          idx_nxt  = lm1[IW-1:0];
          step_nxt = step_r + CW'(1);
          st_nxt   = {1'b0, S_TL_RD};
        end
      end
      S_FIN: begin
        b_we      = 1'b1;
        b_wd      = {e_r, CW'(0)};
        fh_nxt    = fhm1;
        orv_nxt   = val_r;
        ostat_nxt = chte_pkg::STAT_OK;
        ostb_nxt  = 1'b1;
        st_nxt    = {1'b0, S_IDLE};
      end
      // remove: move the last dense entry into the hole
      S_R_LRD: st_nxt = {1'b0, S_R_LE};
      S_R_LE: begin
        lent_nxt = e_rd_r;
        idx_nxt  = rd_home;
        step_nxt = '0;
        st_nxt   = {1'b0, S_R_IRD};
      end
      S_R_IRD: st_nxt = {1'b0, S_R_IB};
      S_R_IB: begin
        if (rd_slot == live_r || step_r == CW'(CAPACITY)) begin
          b_we   = 1'b1;
          b_wd   = {slot_r, rd_link};
          st_nxt = {1'b0, S_R_EW};
        end else begin
          idx_nxt  = lm1[IW-1:0];
          step_nxt = step_r + CW'(1);
          st_nxt   = {1'b0, S_R_IRD};
        end
      end
      S_R_EW: begin
        tmp    = slot_r - CW'(1);
        e_we   = 1'b1;
        e_wa   = tmp[IW-1:0];
        e_wd   = lent_r;
        st_nxt = {1'b0, S_R_LINK};
      end
      // remove: unlink or compact the chain
      S_R_LINK: begin
        live_nxt = live_r - CW'(1);
        tmp      = link_r - CW'(1);
        priority if (prev_v_r) begin
          idx_nxt = prev_r;
          st_nxt  = {1'b0, S_R_PRD};
        end else if (link_r != '0) begin
          idx_nxt = tmp[IW-1:0];
          st_nxt  = {1'b0, S_R_NRD};
        end else begin
          clr_nxt = CW'(bkt_r) + CW'(1);
          st_nxt  = {1'b1, S_CLR};
        end
      end
      S_R_PRD: st_nxt = {1'b0, S_R_PB};
      S_R_PB: begin
        b_we    = 1'b1;
        b_wd    = {rd_slot, link_r};
        clr_nxt = CW'(bkt_r) + CW'(1);
        st_nxt  = {1'b1, S_CLR};
      end
      S_R_NRD: st_nxt = {1'b0, S_R_NB};
      S_R_NB: begin
        b_we    = 1'b1;
        b_wa    = bkt_r;
        b_wd    = b_rd_r;
        clr_nxt = link_r;
        st_nxt  = {1'b1, S_CLR};
      end
      default: st_nxt = {1'b0, S_IDLE};
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= {1'b0, S_CLR};
      idx_r    <= '0;
      eidx_r   <= '0;
      live_r   <= '0;
      fh_r     <= CW'(CAPACITY);
      step_r   <= '0;
      prev_v_r <= 1'b0;
      ostb_r   <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      idx_r    <= idx_nxt;
      eidx_r   <= eidx_nxt;
      live_r   <= live_nxt;
      fh_r     <= fh_nxt;
      step_r   <= step_nxt;
      prev_v_r <= prev_v_nxt;
      ostb_r   <= ostb_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    home_r   <= home_nxt;
    val_r    <= val_nxt;
    prev_r   <= prev_nxt;
    bkt_r    <= bkt_nxt;
    slot_r   <= slot_nxt;
    link_r   <= link_nxt;
    e_r      <= e_nxt;
    hs_r     <= hs_nxt;
    hl_r     <= hl_nxt;
    fb_r     <= fb_nxt;
    clr_r    <= clr_nxt;
    lent_r   <= lent_nxt;
    ofound_r <= ofound_nxt;
    orv_r    <= orv_nxt;
    ostat_r  <= ostat_nxt;
  end

endmodule
